>>> rtl/fcs_pkg.sv
// Shared types and constants of the fixed clock selector.
package fcs_pkg;

    localparam int FREQ_W         = 31;
    localparam int SEL_W          = 8;
    localparam int KIND_W         = 3;
    localparam int IN_IDX_W       = 3;
    localparam int RATIO_W        = 16;
    localparam int PROD_W         = FREQ_W + RATIO_W;
    localparam int Q_W            = FREQ_W;
    localparam int DCLK_W         = 32;
    localparam int OUT_IDX_W      = 3;
    localparam int TH_W           = 39;
    localparam int PCT_SCALE      = 100;
    localparam int DEF_NUM_CLOCKS = 8;

    localparam int S_FIELDS_W = KIND_W + IN_IDX_W + FREQ_W + SEL_W + FREQ_W + 2 * RATIO_W;
    localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 1 + DCLK_W + SEL_W + OUT_IDX_W;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_DATA_W - M_FIELDS_W;

    localparam logic [FREQ_W-1:0] FREQ_MAX = {FREQ_W{1'b1}};
    localparam logic [DCLK_W-1:0] DCLK_ERR = {DCLK_W{1'b1}};

    localparam logic [KIND_W-1:0] REQ_LOAD    = 3'd0;
    localparam logic [KIND_W-1:0] REQ_PROPOSE = 3'd1;
    localparam logic [KIND_W-1:0] REQ_LOWER   = 3'd2;
    localparam logic [KIND_W-1:0] REQ_RAISE   = 3'd3;
    localparam logic [KIND_W-1:0] REQ_CHECK   = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_THR,
        ST_DECIDE,
        ST_STEP_RD,
        ST_STEP_CMP,
        ST_DONE
    } fcs_state_t;

    typedef struct packed {
        logic              en;
        logic [FREQ_W-1:0] freq;
        logic [SEL_W-1:0]  sel;
    } tbl_wr_t;

    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic [SEL_W-1:0]  sel;
    } tbl_ent_t;

endpackage

>>> rtl/fixed_clock_selector.sv
// Fixed clock selector: table of fixed clocks searched for the nearest match to a dot clock.
//
// Channel   Direction  Handshake             Payload
// s_        in         s_tvalid / s_tready   s_tdata: request fields
// m_        out        m_tvalid / m_tready   m_tdata: status, dot clock, select, index
//
// Loads and unknown requests set the result register on acceptance.
// Others share one 31x16 multiplier and a bit-serial divider. Lower, raise and check
// divide for the target, scan the table, test the threshold, decide, may read a step
// entry, then divide for the dot clock unless they fail; propose starts at the scan.
// Reset clears the table valid bits, the sequencer and the output valid flag at once.
// A new request is taken only in the idle state; a result waiting on m_tready holds
// the sequencer in its final state until the output register frees.
module fixed_clock_selector import fcs_pkg::*; #(
    parameter int NUM_CLOCKS = DEF_NUM_CLOCKS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // req_type, entry_index, entry_freq, entry_select, pixel_clock, ratio_mul, ratio_div
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // status, dot_clock_out, select_code, chosen_index
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int IDX_W = (NUM_CLOCKS > 1) ? $clog2(NUM_CLOCKS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CLOCKS - 1);

    // Request fields
    logic [KIND_W-1:0]   in_kind;
    logic [IN_IDX_W-1:0] in_index;
    logic [FREQ_W-1:0]   in_freq;
    logic [SEL_W-1:0]    in_sel;
    logic [FREQ_W-1:0]   in_pclk;
    logic [RATIO_W-1:0]  in_mul;
    logic [RATIO_W-1:0]  in_div;

    assign in_kind  = s_tdata[2:0];
    assign in_index = s_tdata[5:3];
    assign in_freq  = s_tdata[36:6];
    assign in_sel   = s_tdata[44:37];
    assign in_pclk  = s_tdata[75:45];
    assign in_mul   = s_tdata[91:76];
    assign in_div   = s_tdata[107:92];

    fcs_state_t state_reg, state_next;

    logic [KIND_W-1:0]        kind_reg, kind_next;
    logic [FREQ_W-1:0]        pclk_reg, pclk_next;
    logic [RATIO_W-1:0]       mul_reg, mul_next;
    logic [RATIO_W-1:0]       dv_reg, dv_next;
    logic [FREQ_W-1:0]        target_reg, target_next;
    logic [PROD_W-1:0]        prod_reg, prod_next;
    logic [IDX_W-1:0]         scan_reg, scan_next;
    logic [IDX_W-1:0]         best_reg, best_next;
    logic signed [DCLK_W-1:0] miss_reg, miss_next;
    logic [FREQ_W-1:0]        best_freq_reg, best_freq_next;
    logic [SEL_W-1:0]         best_sel_reg, best_sel_next;
    logic                     is_res_reg, is_res_next;
    logic                     res_status_reg, res_status_next;
    logic [DCLK_W-1:0]        res_dclk_reg, res_dclk_next;
    logic [SEL_W-1:0]         res_sel_reg, res_sel_next;
    logic [OUT_IDX_W-1:0]     res_idx_reg, res_idx_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]      m_tdata_reg, m_tdata_next;

    // Control
    logic               accept;
    logic               out_load;
    logic               div_start;
    logic               div_done;
    logic [Q_W-1:0]     div_quo;
    logic [RATIO_W-1:0] div_den;
    logic [FREQ_W-1:0]  mul_a;
    logic [RATIO_W-1:0] mul_b;
    logic [PROD_W-1:0]  mul_out;
    tbl_wr_t            tbl_wr;
    logic [IDX_W-1:0]   tbl_waddr;
    tbl_ent_t           rd_ent;

    // Datapath flags
    logic signed [DCLK_W-1:0] cur_d;
    logic [DCLK_W-1:0]        neg_d;
    logic [DCLK_W-1:0]        neg_miss;
    logic [FREQ_W-1:0]        abs_d;
    logic [FREQ_W-1:0]        abs_miss;
    logic                     scan_take;
    logic                     scan_end;
    logic [TH_W-1:0]          m100;
    logic                     ge2;
    logic                     lt1;
    logic                     miss_pos;
    logic                     miss_neg;
    logic                     dec_fail;
    logic                     dec_step;
    logic [IDX_W-1:0]         step_addr;
    logic                     rd_zero;

    assign accept   = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    assign cur_d    = $signed({1'b0, rd_ent.freq}) - $signed({1'b0, target_reg});
    assign neg_d    = -cur_d;
    assign neg_miss = -miss_reg;
    assign abs_d    = cur_d[DCLK_W-1] ? neg_d[FREQ_W-1:0] : cur_d[FREQ_W-1:0];
    assign abs_miss = miss_reg[DCLK_W-1] ? neg_miss[FREQ_W-1:0] : miss_reg[FREQ_W-1:0];
    assign rd_zero  = (rd_ent.freq == '0);

    // The first entry always seeds the nearest match; a later one must be nonzero and
    // strictly closer.
    assign scan_take = (scan_reg == '0) || (!rd_zero && (abs_d < abs_miss));
    assign scan_end  = rd_zero || (scan_reg == LAST_IDX);

    // |miss| >= floor(2t/100) is 2t <= 100|miss| + 99; |miss| < floor(t/100) is
    // t >= 100|miss| + 100.
    assign m100 = prod_reg[TH_W-1:0];
    assign ge2  = TH_W'({target_reg, 1'b0}) <= (m100 + TH_W'(PCT_SCALE - 1));
    assign lt1  = TH_W'(target_reg) >= (m100 + TH_W'(PCT_SCALE));

    assign miss_pos = !miss_reg[DCLK_W-1] && (miss_reg != '0);
    assign miss_neg = miss_reg[DCLK_W-1];

    always_comb begin
        dec_fail  = 1'b0;
        dec_step  = 1'b0;
        step_addr = best_reg;
        case (kind_reg)
            REQ_LOWER: begin
                if (miss_pos && ge2) begin
                    if (best_reg == LAST_IDX) begin
                        dec_fail = 1'b1;
                    end else begin
                        dec_step  = 1'b1;
                        step_addr = best_reg + IDX_W'(1);
                    end
                end
            end
            REQ_RAISE: begin
                if (miss_neg && ge2) begin
                    if (best_reg == '0) begin
                        dec_fail = 1'b1;
                    end else begin
                        dec_step  = 1'b1;
                        step_addr = best_reg - IDX_W'(1);
                    end
                end
            end
            REQ_CHECK: begin
                dec_fail = !(lt1 && (best_freq_reg != '0));
            end
            default: begin
                dec_fail = 1'b0;
            end
        endcase
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (in_kind == REQ_PROPOSE) begin
                        state_next = ST_SCAN_RD;
                    end else if (in_kind == REQ_LOWER || in_kind == REQ_RAISE ||
                                 in_kind == REQ_CHECK) begin
                        state_next = ST_MUL;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_MUL:      state_next = ST_DIV_GO;
            ST_DIV_GO:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_done) begin
                    state_next = is_res_reg ? ST_DONE : ST_SCAN_RD;
                end
            end
            ST_SCAN_RD:  state_next = ST_SCAN_CMP;
            ST_SCAN_CMP: state_next = scan_end ? ST_THR : ST_SCAN_RD;
            ST_THR:      state_next = ST_DECIDE;
            ST_DECIDE: begin
                if (dec_fail) begin
                    state_next = ST_DONE;
                end else if (dec_step) begin
                    state_next = ST_STEP_RD;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_STEP_RD:  state_next = ST_STEP_CMP;
            ST_STEP_CMP: state_next = rd_zero ? ST_DONE : ST_MUL;
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        s_tready   = (state_reg == ST_IDLE);
        div_start  = (state_reg == ST_DIV_GO);
        div_den    = is_res_reg ? mul_reg : dv_reg;
        tbl_wr.en  = accept && (in_kind == REQ_LOAD) &&
                     (32'(in_index) < 32'(NUM_CLOCKS));
        tbl_wr.freq = in_freq;
        tbl_wr.sel  = in_sel;
        tbl_waddr   = IDX_W'(in_index);
        case (state_reg)
            ST_THR: begin
                mul_a = abs_miss;
                mul_b = RATIO_W'(PCT_SCALE);
            end
            default: begin
                mul_a = is_res_reg ? best_freq_reg : pclk_reg;
                mul_b = is_res_reg ? dv_reg : mul_reg;
            end
        endcase
    end

    assign mul_out = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Register next values
    always_comb begin
        kind_next       = kind_reg;
        pclk_next       = pclk_reg;
        mul_next        = mul_reg;
        dv_next         = dv_reg;
        target_next     = target_reg;
        prod_next       = prod_reg;
        scan_next       = scan_reg;
        best_next       = best_reg;
        miss_next       = miss_reg;
        best_freq_next  = best_freq_reg;
        best_sel_next   = best_sel_reg;
        is_res_next     = is_res_reg;
        res_status_next = res_status_reg;
        res_dclk_next   = res_dclk_reg;
        res_sel_next    = res_sel_reg;
        res_idx_next    = res_idx_reg;
        m_tdata_next    = m_tdata_reg;
        m_tvalid_next   = m_tvalid_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    kind_next   = in_kind;
                    pclk_next   = in_pclk;
                    mul_next    = in_mul;
                    dv_next     = in_div;
                    target_next = FREQ_MAX;
                    is_res_next = 1'b0;
                    scan_next   = '0;
                    best_next   = '0;
                    res_sel_next = '0;
                    if (in_kind == REQ_LOAD) begin
                        res_status_next = 1'b0;
                        res_dclk_next   = '0;
                        res_idx_next    = in_index;
                    end else begin
                        res_status_next = 1'b1;
                        res_dclk_next   = DCLK_ERR;
                        res_idx_next    = '0;
                    end
                end
            end
            ST_MUL, ST_THR: begin
                prod_next = mul_out;
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    if (is_res_reg) begin
                        res_dclk_next = DCLK_W'(div_quo);
                    end else begin
                        target_next = div_quo;
                    end
                end
            end
            ST_SCAN_CMP: begin
                if (scan_take) begin
                    best_next      = scan_reg;
                    miss_next      = cur_d;
                    best_freq_next = rd_ent.freq;
                    best_sel_next  = rd_ent.sel;
                end
                if (!scan_end) begin
                    scan_next = scan_reg + IDX_W'(1);
                end
            end
            ST_DECIDE: begin
                is_res_next     = 1'b1;
                res_status_next = dec_fail;
                res_dclk_next   = DCLK_ERR;
                res_sel_next    = (!dec_fail && kind_reg == REQ_CHECK) ? best_sel_reg : '0;
                res_idx_next    = OUT_IDX_W'(best_reg);
                scan_next       = step_addr;
            end
            ST_STEP_CMP: begin
                if (rd_zero) begin
                    res_status_next = 1'b1;
                    res_dclk_next   = DCLK_ERR;
                end else begin
                    best_next      = scan_reg;
                    best_freq_next = rd_ent.freq;
                    res_idx_next   = OUT_IDX_W'(scan_reg);
                end
            end
            default: begin
                prod_next = prod_reg;
            end
        endcase

        if (out_load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {{M_PAD_W{1'b0}}, res_idx_reg, res_sel_reg, res_dclk_reg,
                             res_status_reg};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            is_res_reg   <= 1'b0;
            scan_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            is_res_reg   <= is_res_next;
            scan_reg     <= scan_next;
        end
        kind_reg       <= kind_next;
        pclk_reg       <= pclk_next;
        mul_reg        <= mul_next;
        dv_reg         <= dv_next;
        target_reg     <= target_next;
        prod_reg       <= prod_next;
        best_reg       <= best_next;
        miss_reg       <= miss_next;
        best_freq_reg  <= best_freq_next;
        best_sel_reg   <= best_sel_next;
        res_status_reg <= res_status_next;
        res_dclk_reg   <= res_dclk_next;
        res_sel_reg    <= res_sel_next;
        res_idx_reg    <= res_idx_next;
        m_tdata_reg    <= m_tdata_next;
    end

    fcs_table #(
        .NUM_CLOCKS(NUM_CLOCKS)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (tbl_wr),
        .waddr   (tbl_waddr),
        .raddr   (scan_reg),
        .rdata   (rd_ent)
    );

    fcs_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (prod_reg),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef ASSERT_OFF
    // The divider only finishes while the sequencer waits for it.
    a_div_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV_WAIT))
        else $error("divider finished outside its wait state");

    // Every error result carries a dot clock of -1.
    a_err_dclk: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> (m_tdata[32:1] == DCLK_ERR))
        else $error("error result without dot clock -1");

    // A select code is only reported with an ok status.
    a_sel_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> (m_tdata[40:33] == '0))
        else $error("select code reported on an error result");

    // A new request is never taken while the previous one is still in progress.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("request accepted back to back");
`endif

endmodule

>>> rtl/fcs_divider.sv
// Restoring divider with a saturated 31-bit quotient, one quotient bit per cycle.
module fcs_divider import fcs_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [PROD_W-1:0]  num,
    input  logic [RATIO_W-1:0] den,
    output logic               done,
    output logic [Q_W-1:0]     quo
);

    localparam int CNT_W = $clog2(Q_W + 1);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [RATIO_W-1:0] rem_reg, rem_next;
    logic [RATIO_W-1:0] den_reg, den_next;
    logic [Q_W-1:0]     qs_reg, qs_next;

    logic [RATIO_W:0]   trial;
    logic [RATIO_W:0]   diff;
    logic               take;
    logic [RATIO_W-1:0] num_high;

    assign num_high = num[PROD_W-1:Q_W];
    assign trial    = {rem_reg, qs_reg[Q_W-1]};
    assign take     = trial >= {1'b0, den_reg};
    assign diff     = trial - {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        qs_next   = qs_reg;
        if (start) begin
            den_next = den;
            // A quotient that needs more than 31 bits (or a zero divisor) saturates at once.
            if (num_high >= den) begin
                qs_next   = FREQ_MAX;
                done_next = 1'b1;
                busy_next = 1'b0;
            end else begin
                rem_next  = num_high;
                qs_next   = num[Q_W-1:0];
                cnt_next  = CNT_W'(Q_W);
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            rem_next = take ? diff[RATIO_W-1:0] : trial[RATIO_W-1:0];
            qs_next  = {qs_reg[Q_W-2:0], take};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        den_reg <= den_next;
        qs_reg  <= qs_next;
    end

    assign done = done_reg;
    assign quo  = qs_reg;

endmodule

>>> rtl/fcs_table.sv
// Clock table memory with per-entry valid bits and a registered read port.
module fcs_table import fcs_pkg::*; #(
    parameter int NUM_CLOCKS = DEF_NUM_CLOCKS,
    localparam int IDX_W = (NUM_CLOCKS > 1) ? $clog2(NUM_CLOCKS) : 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  tbl_wr_t          wr,
    input  logic [IDX_W-1:0] waddr,
    input  logic [IDX_W-1:0] raddr,
    output tbl_ent_t         rdata
);

    logic [NUM_CLOCKS-1:0] vld_reg;
    tbl_ent_t              mem [NUM_CLOCKS];
    tbl_ent_t              rd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (wr.en) begin
            vld_reg[waddr] <= 1'b1;
        end
    end

    // An entry never written since reset reads as zero, which ends the table.
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[waddr] <= '{freq: wr.freq, sel: wr.sel};
        end
        rd_reg <= vld_reg[raddr] ? mem[raddr] : '0;
    end

    assign rdata = rd_reg;

endmodule

>>> sim/tb_fixed_clock_selector.sv
`timescale 1ns / 100ps
// Self-checking testbench for the fixed clock selector: table loads and clock requests.
module tb_fixed_clock_selector;
    import fcs_pkg::*;

    localparam int     NCLK        = DEF_NUM_CLOCKS;
    localparam int     RUN_ITEMS   = 1200;
    localparam int     QUIET_TAIL  = 150;
    localparam int     CYCLE_LIMIT = 800_000;
    localparam int     DRAIN_WAIT  = 100;
    localparam longint SAT         = 64'h7fff_ffff;

    typedef struct {
        logic [KIND_W-1:0]   kind;
        logic [IN_IDX_W-1:0] slot;
        logic [FREQ_W-1:0]   freq;
        logic [SEL_W-1:0]    code;
        logic [FREQ_W-1:0]   pclk;
        logic [RATIO_W-1:0]  rmul;
        logic [RATIO_W-1:0]  rdiv;
    } clk_request_t;

    typedef struct {
        logic                 st;
        logic [DCLK_W-1:0]    dclk;
        logic [SEL_W-1:0]     code;
        logic [OUT_IDX_W-1:0] slot;
    } clk_answer_t;

    class selector_board;
        logic [FREQ_W-1:0] freq_copy [NCLK];
        logic [SEL_W-1:0]  code_copy [NCLK];
        clk_answer_t       pending_answers [$];
        int                fails;

        function new();
            for (int i = 0; i < NCLK; i++) begin
                freq_copy[i] = '0;
                code_copy[i] = '0;
            end
            fails = 0;
        endfunction

        function longint clamp_quot(longint num, longint den);
            longint q;
            if (den == 0) return SAT;
            q = num / den;
            return (q > SAT) ? SAT : q;
        endfunction

        function longint mag(longint v);
            return (v < 0) ? -v : v;
        endfunction

        function int pending();
            return pending_answers.size();
        endfunction

        // Updates the table copy and queues the answer this request must produce.
        function void note_request(clk_request_t r);
            clk_answer_t a;
            longint      target, miss, d, thr;
            int          best;
            logic        bad;
            a    = '{st: 1'b0, dclk: '0, code: '0, slot: '0};
            best = 0;
            bad  = 1'b0;
            if (r.kind == REQ_LOAD) begin
                if (r.slot < NCLK) begin
                    freq_copy[r.slot] = r.freq;
                    code_copy[r.slot] = r.code;
                end
                a.slot = r.slot;
            end else if (r.kind > REQ_CHECK) begin
                a.st   = 1'b1;
                a.dclk = DCLK_ERR;
            end else begin
                target = (r.kind == REQ_PROPOSE) ? SAT :
                         clamp_quot(longint'(r.pclk) * longint'(r.rmul), longint'(r.rdiv));
                // The scan stops at the first empty slot.
                miss = longint'(freq_copy[0]) - target;
                for (int i = 0; i < NCLK && freq_copy[i] != 0; i++) begin
                    d = longint'(freq_copy[i]) - target;
                    if (mag(d) < mag(miss)) begin
                        best = i;
                        miss = d;
                    end
                end
                thr = 2 * target / PCT_SCALE;
                case (r.kind)
                    REQ_LOWER: begin
                        if (miss > 0 && mag(miss) >= thr) begin
                            if (best + 1 >= NCLK || freq_copy[best + 1] == 0) bad = 1'b1;
                            else best++;
                        end
                    end
                    REQ_RAISE: begin
                        if (miss < 0 && mag(miss) >= thr) begin
                            if (best == 0) bad = 1'b1;
                            else best--;
                        end
                    end
                    REQ_CHECK: begin
                        if (!(mag(miss) < target / PCT_SCALE && freq_copy[best] != 0))
                            bad = 1'b1;
                    end
                    default: ;
                endcase
                a.slot = OUT_IDX_W'(best);
                if (bad) begin
                    a.st   = 1'b1;
                    a.dclk = DCLK_ERR;
                end else begin
                    a.dclk = DCLK_W'(clamp_quot(longint'(freq_copy[best]) * longint'(r.rdiv),
                                                longint'(r.rmul)));
                    if (r.kind == REQ_CHECK) a.code = code_copy[best];
                end
            end
            pending_answers.push_back(a);
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            fails++;
        endtask

        task check_result(logic [M_DATA_W-1:0] d);
            clk_answer_t want, got;
            got.st   = d[0];
            got.dclk = d[DCLK_W:1];
            got.code = d[DCLK_W+SEL_W:DCLK_W+1];
            got.slot = d[M_FIELDS_W-1:DCLK_W+SEL_W+1];
            if (pending_answers.size() == 0) begin
                report("result arrived with no request outstanding");
                return;
            end
            want = pending_answers.pop_front();
            if (got.st !== want.st)
                report($sformatf("status %0d, expected %0d", got.st, want.st));
            if (got.dclk !== want.dclk)
                report($sformatf("dot clock %0h, expected %0h", got.dclk, want.dclk));
            if (got.code !== want.code)
                report($sformatf("select code %0h, expected %0h", got.code, want.code));
            if (got.slot !== want.slot)
                report($sformatf("index %0d, expected %0d", got.slot, want.slot));
        endtask
    endclass

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    bit            gaps_on = 1'b1;
    int            sent    = 0;
    int            cycles  = 0;
    selector_board board;

    fixed_clock_selector #(.NUM_CLOCKS(NCLK)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb_fixed_clock_selector NOT OK");
            $finish;
        end
    end

    function automatic clk_request_t make_item(logic [KIND_W-1:0] kind,
                                               logic [IN_IDX_W-1:0] slot,
                                               logic [FREQ_W-1:0] freq,
                                               logic [SEL_W-1:0] code,
                                               logic [FREQ_W-1:0] pclk,
                                               logic [RATIO_W-1:0] rmul,
                                               logic [RATIO_W-1:0] rdiv);
        clk_request_t r;
        r = '{kind: kind, slot: slot, freq: freq, code: code, pclk: pclk, rmul: rmul, rdiv: rdiv};
        return r;
    endfunction

    function automatic clk_request_t noise_item(logic [KIND_W-1:0] kind);
        return make_item(kind, IN_IDX_W'($urandom), FREQ_W'($urandom), SEL_W'($urandom),
                         FREQ_W'($urandom), RATIO_W'($urandom), RATIO_W'($urandom));
    endfunction

    task automatic send_item(input clk_request_t r);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W - S_FIELDS_W){1'b0}},
                     r.rdiv, r.rmul, r.pclk, r.code, r.freq, r.slot, r.kind};
        do begin
            @(posedge aclk);
        end while (!s_tready);
        board.note_request(r);
        sent++;
        gaps_on = (sent < RUN_ITEMS - QUIET_TAIL);
    endtask

    task automatic run_directed();
        send_item(make_item(REQ_PROPOSE, 0, 0, 0, 0, 1, 1));
        send_item(make_item(REQ_CHECK, 0, 0, 0, 25_000_000, 1, 1));
        send_item(make_item(REQ_LOWER, 0, 0, 0, 25_000_000, 1, 1));
        send_item(make_item(REQ_RAISE, 7, FREQ_MAX, 8'hff, FREQ_MAX, 16'hffff, 16'hffff));
        for (int k = REQ_CHECK + 1; k < 2 ** KIND_W; k++)
            send_item(make_item(KIND_W'(k), 5, FREQ_MAX, 8'h5a, 40_000_000, 1, 1));
        send_item(make_item(REQ_LOAD, 0, 25_175_000, 8'h00, 0, 1, 1));
        send_item(make_item(REQ_LOAD, 1, 28_322_000, 8'h55, 0, 1, 1));
        send_item(make_item(REQ_LOAD, 2, 40_000_000, 8'haa, 0, 1, 1));
        send_item(make_item(REQ_LOAD, 3, 65_000_000, 8'hff, 0, 1, 1));
        send_item(make_item(REQ_PROPOSE, 0, 0, 0, 0, 3, 2));
        send_item(make_item(REQ_CHECK, 0, 0, 0, 40_000_000, 1, 1));
        send_item(make_item(REQ_CHECK, 0, 0, 0, 30_000_000, 1, 1));
        // Nearest entry is the last one before the empty slot, so lowering runs off the end.
        send_item(make_item(REQ_LOWER, 0, 0, 0, 60_000_000, 1, 1));
        // Nearest entry is slot zero and sits below the target, so raising has nowhere to go.
        send_item(make_item(REQ_RAISE, 0, 0, 0, 26_000_000, 1, 1));
        send_item(make_item(REQ_LOWER, 0, 0, 0, 24_000_000, 1, 1));
        send_item(make_item(REQ_RAISE, 0, 0, 0, 30_000_000, 1, 1));
        send_item(make_item(REQ_CHECK, 0, 0, 0, 40_000_000, 1, 0));
        send_item(make_item(REQ_PROPOSE, 0, 0, 0, 0, 0, 16'hffff));
        send_item(make_item(REQ_CHECK, 0, 0, 0, FREQ_MAX, 16'hffff, 1));
        send_item(make_item(REQ_LOAD, 4, 80_000_000, 8'h01, 0, 1, 1));
        send_item(make_item(REQ_LOAD, 5, 100_000_000, 8'h80, 0, 1, 1));
        send_item(make_item(REQ_LOAD, 6, 135_000_000, 8'h7f, 0, 1, 1));
        send_item(make_item(REQ_LOAD, 7, FREQ_MAX, 8'hc3, 0, 1, 1));
        // A full table: lowering from the top slot steps past the table size.
        send_item(make_item(REQ_LOWER, 0, 0, 0, 1_900_000_000, 1, 1));
    endtask

    // Loads a fresh table of random length, then aims a burst of requests at it.
    task automatic run_phase();
        longint       freqs [NCLK];
        longint       f, t, p;
        int           n, j, pick;
        bit           wild;
        clk_request_t r;
        n    = $urandom_range(0, NCLK);
        wild = ($urandom_range(0, 4) == 0);
        f    = longint'($urandom_range(1_000_000, 60_000_000));
        for (int i = 0; i < NCLK; i++) begin
            r      = noise_item(REQ_LOAD);
            r.slot = IN_IDX_W'(i);
            if (i >= n) begin
                r.freq = '0;
            end else if (!wild) begin
                r.freq = FREQ_W'(f);
                f = f + f * longint'($urandom_range(3, 50)) / 100;
                if (f > SAT) f = SAT;
            end
            freqs[i] = longint'(r.freq);
            // Slots past the terminator keep stale contents on purpose.
            if (i <= n) send_item(r);
        end
        repeat ($urandom_range(4, 20)) begin
            r    = noise_item(KIND_W'($urandom_range(REQ_PROPOSE, REQ_CHECK)));
            pick = $urandom_range(0, 39);
            if (pick == 0) begin
                r.kind = KIND_W'($urandom_range(REQ_CHECK + 1, 2 ** KIND_W - 1));
            end else if (pick == 1) begin
                r.kind = REQ_LOAD;
            end else if (pick < 30 && n > 0) begin
                j = $urandom_range(0, n - 1);
                t = freqs[j] + freqs[j] * (longint'($urandom_range(0, 60_000)) - 30_000)
                    / 1_000_000;
                if ($urandom_range(0, 4) != 0) begin
                    r.rmul = RATIO_W'($urandom_range(1, 16));
                    r.rdiv = RATIO_W'($urandom_range(1, 16));
                end
                if (r.rmul != 0) begin
                    p = t * longint'(r.rdiv) / longint'(r.rmul);
                    r.pclk = (p > SAT) ? FREQ_MAX : FREQ_W'(p);
                end
            end else if (pick < 35) begin
                r.rmul = RATIO_W'($urandom_range(1, 16));
                r.rdiv = RATIO_W'($urandom_range(1, 16));
                r.pclk = FREQ_W'($urandom_range(0, 200_000_000));
            end
            send_item(r);
        end
    endtask

    initial begin : result_sink
        int hold;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata);
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                hold = $urandom_range(0, 10);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        board = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        while (sent < RUN_ITEMS) run_phase();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (board.fails == 0) begin
            $display("tb_fixed_clock_selector OK");
        end else begin
            $display("tb_fixed_clock_selector NOT OK");
        end
        $finish;
    end

endmodule

>>> fixed_clock_selector.f
rtl/fcs_pkg.sv
rtl/fcs_divider.sv
rtl/fcs_table.sv
rtl/fixed_clock_selector.sv
sim/tb_fixed_clock_selector.sv
